@@ rtl/core/phbd_pkg.sv @@
package phbd_pkg;

  localparam int RING_DEPTH = 32;
  localparam int RING_AW    = $clog2(RING_DEPTH);

  localparam int SAMPLE_W = 18;
  localparam int DATA_W   = 16;
  localparam int ACC_W    = 32;
  localparam int CFG_W    = 64;
  localparam int CFG_IW   = 3;

  // symmetric 23-tap FIR: taps 0..10 paired with 22..12, tap 11 alone
  localparam int FIR_HALF = 11;
  localparam int FIR_SPAN = 22;
  localparam int DC_SHIFT = 4;
  localparam int Q_SHIFT  = 15;

  localparam logic [CFG_IW-1:0] REG_COEFF0    = 3'd0;
  localparam logic [CFG_IW-1:0] REG_COEFF1    = 3'd1;
  localparam logic [CFG_IW-1:0] REG_COEFF2    = 3'd2;
  localparam logic [CFG_IW-1:0] REG_MIN_SWING = 3'd3;
  localparam logic [CFG_IW-1:0] REG_MAX_SWING = 3'd4;

  localparam logic [DATA_W-1:0] MIN_SWING_RST = 16'd20;
  localparam logic [DATA_W-1:0] MAX_SWING_RST = 16'd1000;

  typedef struct packed {
    logic                 we;
    logic [RING_AW-1:0]   addr;
    logic [DATA_W-1:0]    data;
  } ring_wr_t;

  typedef struct packed {
    logic [RING_AW-1:0]   addr_a;
    logic [RING_AW-1:0]   addr_b;
  } ring_rd_t;

  typedef struct packed {
    logic                 clear;
    logic                 op_v;
    logic [DATA_W-1:0]    op;
    logic [DATA_W-1:0]    coef;
  } mac_ctl_t;

endpackage

@@ rtl/core/phbd_if.sv @@
interface phbd_in_if;
  logic                             valid;
  logic                             ready;
  logic [phbd_pkg::SAMPLE_W-1:0]    sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface phbd_out_if;
  logic                             valid;
  logic                             ready;
  logic                             beat;
  logic signed [phbd_pkg::DATA_W-1:0] ac_value;
  logic signed [phbd_pkg::DATA_W-1:0] dc_estimate;

  modport source (output valid, output beat, output ac_value, output dc_estimate,
                  input ready);
  modport sink   (input valid, input beat, input ac_value, input dc_estimate,
                  output ready);
endinterface

@@ rtl/core/phbd_ring.sv @@
module phbd_ring (
  input  logic                          clk,
  input  logic                          rst_n,
  input  phbd_pkg::ring_wr_t            wr,
  input  phbd_pkg::ring_rd_t            rd,
  output logic [phbd_pkg::DATA_W-1:0]   dat_a,
  output logic [phbd_pkg::DATA_W-1:0]   dat_b
);

  logic [phbd_pkg::DATA_W-1:0]     mem [phbd_pkg::RING_DEPTH];
  logic [phbd_pkg::RING_DEPTH-1:0] valid_r;
  logic [phbd_pkg::DATA_W-1:0]     rd_a_r;
  logic [phbd_pkg::DATA_W-1:0]     rd_b_r;
  logic                            va_r;
  logic                            vb_r;

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.addr] <= wr.data;
    end
    rd_a_r <= mem[rd.addr_a];
    rd_b_r <= mem[rd.addr_b];
  end

  // entries never written read as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      va_r    <= 1'b0;
      vb_r    <= 1'b0;
    end else begin
      if (wr.we) begin
        valid_r[wr.addr] <= 1'b1;
      end
      va_r <= valid_r[rd.addr_a];
      vb_r <= valid_r[rd.addr_b];
    end
  end

  assign dat_a = va_r ? rd_a_r : '0;
  assign dat_b = vb_r ? rd_b_r : '0;

endmodule

@@ rtl/core/phbd_mac.sv @@
module phbd_mac (
  input  logic                          clk,
  input  logic                          rst_n,
  input  phbd_pkg::mac_ctl_t            ctl,
  output logic [phbd_pkg::ACC_W-1:0]    acc
);

  logic signed [phbd_pkg::ACC_W-1:0] prod_r;
  logic                              pv_r;
  logic [phbd_pkg::ACC_W-1:0]        acc_r;

  always_ff @(posedge clk) begin
    prod_r <= $signed(ctl.op) * $signed(ctl.coef);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r  <= 1'b0;
      acc_r <= '0;
    end else begin
      pv_r <= ctl.op_v && !ctl.clear;
      if (ctl.clear) begin
        acc_r <= '0;
      end else if (pv_r) begin
        acc_r <= acc_r + prod_r;  // wraps mod 2^32
      end
    end
  end

  assign acc = acc_r;

endmodule

@@ rtl/core/phbd_detect.sv @@
module phbd_detect (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 upd,
  input  logic signed [phbd_pkg::DATA_W-1:0]   ac_new,
  input  logic [phbd_pkg::DATA_W-1:0]          min_swing,
  input  logic [phbd_pkg::DATA_W-1:0]          max_swing,
  output logic                                 beat
);

  logic signed [phbd_pkg::DATA_W-1:0] ac_now_r;
  logic signed [phbd_pkg::DATA_W-1:0] run_peak_r;
  logic signed [phbd_pkg::DATA_W-1:0] run_peak_nxt;
  logic signed [phbd_pkg::DATA_W-1:0] run_trough_r;
  logic signed [phbd_pkg::DATA_W-1:0] run_trough_nxt;
  logic                               rising_r;
  logic                               rising_nxt;
  logic                               falling_r;
  logic                               falling_nxt;
  logic                               rise;
  logic                               fall;
  logic signed [phbd_pkg::DATA_W:0]   swing;
  logic signed [phbd_pkg::DATA_W+1:0] swing_x;
  logic signed [phbd_pkg::DATA_W+1:0] min_x;
  logic signed [phbd_pkg::DATA_W+1:0] max_x;

  always_comb begin
    rise = (ac_now_r < 0) && (ac_new >= 0);
    fall = (ac_now_r > 0) && (ac_new <= 0);

    // swing uses the peak and trough latched at this crossing
    swing   = {run_peak_r[phbd_pkg::DATA_W-1], run_peak_r}
            - {run_trough_r[phbd_pkg::DATA_W-1], run_trough_r};
    swing_x = {swing[phbd_pkg::DATA_W], swing};
    min_x   = {2'b00, min_swing};
    max_x   = {2'b00, max_swing};
    beat    = rise && (swing_x > min_x) && (swing_x < max_x);

    rising_nxt     = rising_r;
    falling_nxt    = falling_r;
    run_peak_nxt   = run_peak_r;
    run_trough_nxt = run_trough_r;
    if (rise) begin
      rising_nxt   = 1'b1;
      falling_nxt  = 1'b0;
      run_peak_nxt = '0;
    end
    if (fall) begin
      rising_nxt     = 1'b0;
      falling_nxt    = 1'b1;
      run_trough_nxt = '0;
    end
    if (rising_nxt && (ac_new > ac_now_r)) begin
      run_peak_nxt = ac_new;
    end
    if (falling_nxt && (ac_new < ac_now_r)) begin
      run_trough_nxt = ac_new;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ac_now_r     <= '0;
      run_peak_r   <= '0;
      run_trough_r <= '0;
      rising_r     <= 1'b0;
      falling_r    <= 1'b0;
    end else if (upd) begin
      ac_now_r     <= ac_new;
      run_peak_r   <= run_peak_nxt;
      run_trough_r <= run_trough_nxt;
      rising_r     <= rising_nxt;
      falling_r    <= falling_nxt;
    end
  end

endmodule

@@ rtl/core/ppg_heart_beat_detector.sv @@
// Each accepted request runs the DC update, the ring write, the FIR and the detect step.
// A new request is not taken until the last one is done; twelve passes through the single
//   16x16 multiply-accumulate unit (plus its two-stage fill) dominate its processing time.
// The next request waits until the output register is free or being emptied.
// Reset: synchronous, active low; clears the control state, accumulators, coefficients, the 32 ring valid bits
//   (no clearing sweep) and sets the swing thresholds to 20 and 1000.
module ppg_heart_beat_detector (
  input  logic                             clk,
  input  logic                             rst_n,
  phbd_in_if.sink                          in_if,
  phbd_out_if.source                       out_if,
  input  logic                             cfg_we,
  input  logic [phbd_pkg::CFG_IW-1:0]      cfg_index,
  input  logic [phbd_pkg::CFG_W-1:0]       cfg_wdata
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DC1  = 3'd1;
  localparam logic [2:0] S_DC2  = 3'd2;
  localparam logic [2:0] S_WR   = 3'd3;
  localparam logic [2:0] S_FIR  = 3'd4;
  localparam logic [2:0] S_DET  = 3'd5;

  localparam int          CNT_W    = 4;
  localparam logic [CNT_W-1:0] K_CTR = CNT_W'(phbd_pkg::FIR_HALF);
  // last issue plus ring read and multiply stages
  localparam logic [CNT_W-1:0] K_END = CNT_W'(phbd_pkg::FIR_HALF + 2);

  localparam int DW = phbd_pkg::DATA_W;
  localparam int AW = phbd_pkg::ACC_W;

  logic [2:0]                      state_r;
  logic [2:0]                      state_nxt;
  logic [CNT_W-1:0]                cnt_r;
  logic [CNT_W-1:0]                cnt_nxt;
  logic [phbd_pkg::RING_AW-1:0]    pos_r;
  logic [phbd_pkg::RING_AW-1:0]    pos_nxt;
  logic [phbd_pkg::SAMPLE_W-1:0]   sample_r;
  logic [AW-1:0]                   dc_acc_r;
  logic [AW-1:0]                   dc_acc_nxt;
  logic signed [AW+1:0]            diff_r;
  logic signed [AW+1:0]            diff_nxt;
  logic [DW-1:0]                   dc_r;

  logic [phbd_pkg::CFG_W-1:0]      cw0_r;
  logic [phbd_pkg::CFG_W-1:0]      cw1_r;
  logic [phbd_pkg::CFG_W-1:0]      cw2_r;
  logic [DW-1:0]                   min_swing_r;
  logic [DW-1:0]                   max_swing_r;

  logic                            iss_v_r;
  logic [CNT_W-1:0]                iss_k_r;
  logic [phbd_pkg::CFG_W-1:0]      cw_sel;
  logic [DW-1:0]                   coef;

  phbd_pkg::ring_wr_t              ring_wr;
  phbd_pkg::ring_rd_t              ring_rd;
  phbd_pkg::mac_ctl_t              mac_ctl;
  logic [DW-1:0]                   tap_a;
  logic [DW-1:0]                   tap_b;
  logic [AW-1:0]                   fir_acc;
  logic signed [DW-1:0]            ac_new;

  logic                            out_free;
  logic                            det_upd;
  logic                            beat;
  logic                            out_v_r;
  logic                            beat_r;
  logic [DW-1:0]                   ac_r;
  logic [DW-1:0]                   dc_out_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cw0_r       <= '0;
      cw1_r       <= '0;
      cw2_r       <= '0;
      min_swing_r <= phbd_pkg::MIN_SWING_RST;
      max_swing_r <= phbd_pkg::MAX_SWING_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        phbd_pkg::REG_COEFF0:    cw0_r <= cfg_wdata;
        phbd_pkg::REG_COEFF1:    cw1_r <= cfg_wdata;
        phbd_pkg::REG_COEFF2:    cw2_r <= cfg_wdata;
        phbd_pkg::REG_MIN_SWING: min_swing_r <= cfg_wdata[DW-1:0];
        phbd_pkg::REG_MAX_SWING: max_swing_r <= cfg_wdata[DW-1:0];
        default: ;
      endcase
    end
  end

  assign in_if.ready = (state_r == S_IDLE);
  assign out_free    = !out_v_r || out_if.ready;
  assign det_upd     = (state_r == S_DET) && out_free;

  // DC tracker: acc += floor((target - acc) / 16), split over the DC1 and DC2 states
  always_comb begin
    diff_nxt   = $signed({3'b000, sample_r[DW-1:0], {phbd_pkg::Q_SHIFT{1'b0}}})
               - $signed({{2{dc_acc_r[AW-1]}}, dc_acc_r});
    dc_acc_nxt = dc_acc_r + AW'(diff_r >>> phbd_pkg::DC_SHIFT);
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    pos_nxt   = pos_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_if.valid) begin
          state_nxt = S_DC1;
        end
      end
      S_DC1: state_nxt = S_DC2;
      S_DC2: state_nxt = S_WR;
      S_WR: begin
        cnt_nxt   = '0;
        state_nxt = S_FIR;
      end
      S_FIR: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == K_END) begin
          pos_nxt   = pos_r + 1'b1;
          state_nxt = S_DET;
        end
      end
      S_DET: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      cnt_r    <= '0;
      pos_r    <= '0;
      dc_acc_r <= '0;
      iss_v_r  <= 1'b0;
      iss_k_r  <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      pos_r   <= pos_nxt;
      if (state_r == S_DC2) begin
        dc_acc_r <= dc_acc_nxt;
      end
      iss_v_r <= (state_r == S_FIR) && (cnt_r <= K_CTR);
      iss_k_r <= cnt_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_if.valid && in_if.ready) begin
      sample_r <= in_if.sample;
    end
    if (state_r == S_DC1) begin
      diff_r <= diff_nxt;
    end
    if (state_r == S_DC2) begin
      dc_r <= dc_acc_nxt[phbd_pkg::Q_SHIFT +: DW];
    end
  end

  // ring write of sample minus DC, then paired tap reads
  always_comb begin
    ring_wr.we     = (state_r == S_WR);
    ring_wr.addr   = pos_r;
    ring_wr.data   = sample_r[DW-1:0] - dc_r;
    ring_rd.addr_a = pos_r - phbd_pkg::RING_AW'(cnt_r);
    ring_rd.addr_b = pos_r - phbd_pkg::RING_AW'(phbd_pkg::FIR_SPAN)
                   + phbd_pkg::RING_AW'(cnt_r);
  end

  phbd_ring u_ring (
    .clk   (clk),
    .rst_n (rst_n),
    .wr    (ring_wr),
    .rd    (ring_rd),
    .dat_a (tap_a),
    .dat_b (tap_b)
  );

  always_comb begin
    unique case (iss_k_r[3:2])
      2'd0:    cw_sel = cw0_r;
      2'd1:    cw_sel = cw1_r;
      default: cw_sel = cw2_r;
    endcase
    coef = cw_sel[iss_k_r[1:0]*DW +: DW];

    mac_ctl.clear = (state_r == S_WR);
    mac_ctl.op_v  = iss_v_r;
    mac_ctl.op    = (iss_k_r == K_CTR) ? tap_a : tap_a + tap_b;
    mac_ctl.coef  = coef;
  end

  phbd_mac u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (mac_ctl),
    .acc   (fir_acc)
  );

  assign ac_new = $signed(fir_acc[phbd_pkg::Q_SHIFT +: DW]);

  phbd_detect u_det (
    .clk       (clk),
    .rst_n     (rst_n),
    .upd       (det_upd),
    .ac_new    (ac_new),
    .min_swing (min_swing_r),
    .max_swing (max_swing_r),
    .beat      (beat)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (det_upd) begin
      out_v_r <= 1'b1;
    end else if (out_if.ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (det_upd) begin
      beat_r   <= beat;
      ac_r     <= ac_new;
      dc_out_r <= dc_r;
    end
  end

  assign out_if.valid       = out_v_r;
  assign out_if.beat        = beat_r;
  assign out_if.ac_value    = $signed(ac_r);
  assign out_if.dc_estimate = $signed(dc_out_r);

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_if.valid && in_if.ready) |=> (state_r == S_DC1))
    else $error("accepted request did not start DC update");

  a_out_from_det: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_v_r) |-> ($past(state_r) == S_DET))
    else $error("result appeared outside detect step");

  a_ready_drop: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(in_if.ready) |-> $past(in_if.valid))
    else $error("ready dropped without a request");

endmodule

@@ verif/ppg_heart_beat_detector_tb.sv @@
`timescale 1ns / 100ps

module ppg_heart_beat_detector_tb;

  localparam int RING_DEPTH = phbd_pkg::RING_DEPTH;
  localparam int RING_AW    = phbd_pkg::RING_AW;
  localparam int SAMPLE_W   = phbd_pkg::SAMPLE_W;
  localparam int DATA_W     = phbd_pkg::DATA_W;
  localparam int ACC_W      = phbd_pkg::ACC_W;
  localparam int CFG_W      = phbd_pkg::CFG_W;
  localparam int CFG_IW     = phbd_pkg::CFG_IW;
  localparam int FIR_HALF   = phbd_pkg::FIR_HALF;
  localparam int FIR_SPAN   = phbd_pkg::FIR_SPAN;
  localparam int DC_SHIFT   = phbd_pkg::DC_SHIFT;
  localparam int Q_SHIFT    = phbd_pkg::Q_SHIFT;

  localparam logic [CFG_IW-1:0] REG_COEFF0    = phbd_pkg::REG_COEFF0;
  localparam logic [CFG_IW-1:0] REG_COEFF1    = phbd_pkg::REG_COEFF1;
  localparam logic [CFG_IW-1:0] REG_COEFF2    = phbd_pkg::REG_COEFF2;
  localparam logic [CFG_IW-1:0] REG_MIN_SWING = phbd_pkg::REG_MIN_SWING;
  localparam logic [CFG_IW-1:0] REG_MAX_SWING = phbd_pkg::REG_MAX_SWING;

  localparam logic [DATA_W-1:0] MIN_SWING_RST = phbd_pkg::MIN_SWING_RST;
  localparam logic [DATA_W-1:0] MAX_SWING_RST = phbd_pkg::MAX_SWING_RST;

  localparam int CYCLE_LIMIT  = 600000;
  localparam int TOTAL_ITEMS  = 1275;
  localparam int PHASE_ITEMS  = 125;
  localparam int MODE_B_AT    = 440;
  localparam int MODE_C_AT    = 860;
  localparam int HOLD_AT      = 1000;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 40;

  localparam logic [CFG_IW-1:0] REG_UNUSED_LO = 3'd5;
  localparam logic [CFG_IW-1:0] REG_UNUSED_HI = 3'd7;

  typedef struct packed {
    logic                     beat;
    logic signed [DATA_W-1:0] ac;
    logic signed [DATA_W-1:0] dc;
  } pulse_rec_t;

  typedef enum logic {ROW_SAMPLE, ROW_REG} row_kind_t;

  typedef struct {
    row_kind_t         kind;
    logic [CFG_IW-1:0] idx;
    logic [CFG_W-1:0]  data;
    bit                typed;
    pulse_rec_t        want;
  } plan_row_t;

  logic              clk;
  logic              rst_n;
  logic              cfg_we;
  logic [CFG_IW-1:0] cfg_index;
  logic [CFG_W-1:0]  cfg_wdata;

  phbd_in_if  in_bus ();
  phbd_out_if out_bus ();

  ppg_heart_beat_detector u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_bus),
    .out_if    (out_bus),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // predictor copy of the registers and the datapath state
  logic [CFG_W-1:0]         coeff_word [3];
  logic [DATA_W-1:0]        min_swing_q;
  logic [DATA_W-1:0]        max_swing_q;
  logic [ACC_W-1:0]         dc_acc;
  logic [DATA_W-1:0]        ring_mem [RING_DEPTH];
  logic [RING_AW-1:0]       ring_wp;
  logic signed [DATA_W-1:0] ac_cur, ac_prev;
  logic signed [DATA_W-1:0] peak_hold, trough_hold;
  logic signed [DATA_W-1:0] peak_run, trough_run;
  logic                     in_rise, in_fall;

  pulse_rec_t pending_pulses [$];
  plan_row_t  plan [$];

  int sent_items    = 0;
  int results_seen  = 0;
  int mismatch_cnt  = 0;
  int send_idle_pct = 28;
  int recv_idle_pct = 53;
  int hold_left     = 0;
  bit hold_used     = 1'b0;
  int watchdog;

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  function automatic int coeff_at(input int k);
    logic [CFG_W-1:0]         w;
    logic signed [DATA_W-1:0] c16;
    w   = coeff_word[k / 4];
    c16 = w[16 * (k % 4) +: 16];
    return c16;
  endfunction

  function automatic pulse_rec_t filter_and_detect(input logic [SAMPLE_W-1:0] s);
    longint                   acc;
    longint                   target;
    logic [ACC_W-1:0]         z;
    logic signed [DATA_W-1:0] dc16, a16, b16, pair16;
    logic [RING_AW-1:0]       ia, ib;
    int                       prod, swing, lo, hi;
    pulse_rec_t               r;

    ac_prev = ac_cur;

    // leaky DC tracker, 1/16 step toward the low 16 bits of the sample
    acc    = $signed(dc_acc);
    target = s[DATA_W-1:0];
    target = target * 32768;
    acc    = acc + ((target - acc) >>> DC_SHIFT);
    dc_acc = acc[ACC_W-1:0];
    acc    = $signed(dc_acc);
    dc16   = DATA_W'(acc >>> Q_SHIFT);

    prod = s;
    prod = prod - dc16;
    ring_mem[ring_wp] = prod[DATA_W-1:0];

    ia   = ring_wp - RING_AW'(FIR_HALF);
    a16  = ring_mem[ia];
    prod = coeff_at(FIR_HALF) * a16;
    z    = prod;
    for (int i = 0; i < FIR_HALF; i++) begin
      ia     = ring_wp - RING_AW'(i);
      ib     = ring_wp - RING_AW'(FIR_SPAN) + RING_AW'(i);
      a16    = ring_mem[ia];
      b16    = ring_mem[ib];
      pair16 = a16 + b16;
      prod   = coeff_at(i) * pair16;
      z      = z + prod;
    end
    ring_wp = ring_wp + 1'b1;
    ac_cur  = DATA_W'($signed(z) >>> Q_SHIFT);

    r.beat = 1'b0;
    if (ac_prev < 0 && ac_cur >= 0) begin
      peak_hold   = peak_run;
      trough_hold = trough_run;
      in_rise     = 1'b1;
      in_fall     = 1'b0;
      peak_run    = '0;
      // full-width swing against the unsigned thresholds
      swing  = peak_hold - trough_hold;
      lo     = min_swing_q;
      hi     = max_swing_q;
      r.beat = (swing > lo) && (swing < hi);
    end
    if (ac_prev > 0 && ac_cur <= 0) begin
      in_rise    = 1'b0;
      in_fall    = 1'b1;
      trough_run = '0;
    end
    if (in_rise && ac_cur > ac_prev) peak_run = ac_cur;
    if (in_fall && ac_cur < ac_prev) trough_run = ac_cur;

    r.ac = ac_cur;
    r.dc = dc16;
    return r;
  endfunction

  function automatic void plan_sample(input logic [SAMPLE_W-1:0] s);
    plan_row_t row;
    row.kind  = ROW_SAMPLE;
    row.idx   = '0;
    row.data  = s;
    row.typed = 1'b0;
    row.want  = '0;
    plan.push_back(row);
  endfunction

  function automatic void plan_typed(input logic [SAMPLE_W-1:0] s, input logic beat,
                                     input logic signed [DATA_W-1:0] ac,
                                     input logic signed [DATA_W-1:0] dc);
    plan_row_t row;
    row.kind  = ROW_SAMPLE;
    row.idx   = '0;
    row.data  = s;
    row.typed = 1'b1;
    row.want  = {beat, ac, dc};
    plan.push_back(row);
  endfunction

  function automatic void plan_reg(input logic [CFG_IW-1:0] idx, input logic [CFG_W-1:0] val);
    plan_row_t row;
    row.kind  = ROW_REG;
    row.idx   = idx;
    row.data  = val;
    row.typed = 1'b0;
    row.want  = '0;
    plan.push_back(row);
  endfunction

  task automatic push_sample(input logic [SAMPLE_W-1:0] s, input bit typed,
                             input pulse_rec_t want);
    pulse_rec_t calc;
    while ($urandom_range(99) < send_idle_pct) begin
      in_bus.valid <= 1'b0;
      @(posedge clk);
    end
    in_bus.valid  <= 1'b1;
    in_bus.sample <= s;
    do @(posedge clk); while (!in_bus.ready);
    calc = filter_and_detect(s);
    pending_pulses.push_back(typed ? want : calc);
    sent_items++;
    if (sent_items < MODE_B_AT) begin
      send_idle_pct = 28;
      recv_idle_pct = 53;
    end else if (sent_items < MODE_C_AT) begin
      send_idle_pct = 53;
      recv_idle_pct = 28;
    end else begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end
  endtask

  // registers only change with the pipeline empty
  task automatic write_reg(input logic [CFG_IW-1:0] idx, input logic [CFG_W-1:0] val);
    in_bus.valid <= 1'b0;
    while (pending_pulses.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_COEFF0:    coeff_word[0] = val;
      REG_COEFF1:    coeff_word[1] = val;
      REG_COEFF2:    coeff_word[2] = val;
      REG_MIN_SWING: min_swing_q = val[DATA_W-1:0];
      REG_MAX_SWING: max_swing_q = val[DATA_W-1:0];
      default: ;
    endcase
  endtask

  // result side: check against the oldest pending request, random backpressure
  always @(posedge clk) begin
    pulse_rec_t want;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      results_seen++;
      if (pending_pulses.size() == 0) begin
        $error("result with no pending request: beat %0d ac %0d dc %0d",
               out_bus.beat, out_bus.ac_value, out_bus.dc_estimate);
        mismatch_cnt++;
      end else begin
        want = pending_pulses.pop_front();
        if (out_bus.beat !== want.beat) begin
          $error("beat: expected %0d, actual %0d", want.beat, out_bus.beat);
          mismatch_cnt++;
        end
        if (out_bus.ac_value !== want.ac) begin
          $error("ac_value: expected %0d, actual %0d", want.ac, out_bus.ac_value);
          mismatch_cnt++;
        end
        if (out_bus.dc_estimate !== want.dc) begin
          $error("dc_estimate: expected %0d, actual %0d", want.dc, out_bus.dc_estimate);
          mismatch_cnt++;
        end
      end
    end
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_bus.ready <= 1'b0;
    end else if (!hold_used && results_seen >= HOLD_AT && in_bus.valid) begin
      // long stall so the block backs up into its input
      hold_used = 1'b1;
      hold_left = HOLD_CYCLES;
      out_bus.ready <= 1'b0;
    end else begin
      out_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  initial begin
    watchdog = 0;
    while (watchdog < CYCLE_LIMIT) begin
      @(posedge clk);
      watchdog++;
    end
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    int                  phase_no;
    int                  phase_end;
    int                  len, period, half, amp, base, hi, ph, v, n, s;
    logic [SAMPLE_W-1:0] noise_s;

    rst_n         <= 1'b0;
    cfg_we        <= 1'b0;
    cfg_index     <= '0;
    cfg_wdata     <= '0;
    in_bus.valid  <= 1'b0;
    in_bus.sample <= '0;

    for (int i = 0; i < 3; i++) coeff_word[i] = '0;
    min_swing_q = MIN_SWING_RST;
    max_swing_q = MAX_SWING_RST;
    dc_acc      = '0;
    for (int i = 0; i < RING_DEPTH; i++) ring_mem[i] = '0;
    ring_wp     = '0;
    ac_cur      = '0;
    ac_prev     = '0;
    peak_hold   = '0;
    trough_hold = '0;
    peak_run    = '0;
    trough_run  = '0;
    in_rise     = 1'b0;
    in_fall     = 1'b0;

    // directed: reset state with zero taps, then taps and thresholds at extremes
    plan_typed(18'h00000, 1'b0, 16'sd0, 16'sd0);
    plan_typed(18'h3FFFF, 1'b0, 16'sd0, 16'sh0FFF);
    plan_sample(18'h20000);
    plan_sample(18'h10000);
    plan_reg(REG_UNUSED_HI, '1);
    plan_sample(18'h3FFFF);
    plan_reg(REG_COEFF2, {16'h7FFF, 48'h0});
    plan_reg(REG_MIN_SWING, 64'h0);
    plan_reg(REG_MAX_SWING, '1);
    for (int k = 0; k < 14; k++) plan_sample(((k / 3) % 2) ? 18'h04000 : 18'h0C000);
    plan_reg(REG_COEFF0, {4{16'h8000}});
    plan_reg(REG_COEFF1, {4{16'h8000}});
    plan_reg(REG_COEFF2, {4{16'h8000}});
    plan_sample(18'h3FFFF);
    plan_sample(18'h00000);
    plan_sample(18'h3FFFF);
    plan_reg(REG_MIN_SWING, 64'hFFFF);
    plan_reg(REG_MAX_SWING, 64'h0);
    plan_sample(18'h0C000);
    plan_sample(18'h04000);

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_REG) write_reg(plan[i].idx, plan[i].data);
      else push_sample(plan[i].data[SAMPLE_W-1:0], plan[i].typed, plan[i].want);
    end

    phase_no = 0;
    while (sent_items < TOTAL_ITEMS) begin
      write_reg(3'($urandom_range(REG_UNUSED_HI, REG_UNUSED_LO)), {$urandom, $urandom});
      case (phase_no % 6)
        0: begin
          write_reg(REG_COEFF0, '0);
          write_reg(REG_COEFF1, '0);
          write_reg(REG_COEFF2, {16'h7FFF, 48'h0});
          write_reg(REG_MIN_SWING, 64'd20);
          write_reg(REG_MAX_SWING, 64'd1000);
        end
        1: begin
          // flat low-pass, taps summing to just under 1.0
          write_reg(REG_COEFF0, {4{16'h0590}});
          write_reg(REG_COEFF1, {4{16'h0590}});
          write_reg(REG_COEFF2, {4{16'h0590}});
          write_reg(REG_MIN_SWING, 64'd20);
          write_reg(REG_MAX_SWING, 64'd1000);
        end
        2: begin
          write_reg(REG_COEFF0, {$urandom, $urandom});
          write_reg(REG_COEFF1, {$urandom, $urandom});
          write_reg(REG_COEFF2, {$urandom, $urandom});
          write_reg(REG_MIN_SWING, {$urandom, 16'($urandom), 16'($urandom_range(100))});
          write_reg(REG_MAX_SWING,
                    {$urandom, 16'($urandom), 16'($urandom_range(65535, 200))});
        end
        3: begin
          write_reg(REG_COEFF0, {4{16'h7FFF}});
          write_reg(REG_COEFF1, {4{16'h7FFF}});
          write_reg(REG_COEFF2, {4{16'h7FFF}});
          write_reg(REG_MIN_SWING, 64'h0);
          write_reg(REG_MAX_SWING, 64'hFFFF);
        end
        4: begin
          write_reg(REG_COEFF0, {4{16'h8000}});
          write_reg(REG_COEFF1, {4{16'h8000}});
          write_reg(REG_COEFF2, {4{16'h8000}});
          write_reg(REG_MIN_SWING, 64'hFFFF);
          write_reg(REG_MAX_SWING, 64'h0);
        end
        default: begin
          write_reg(REG_COEFF0, '0);
          write_reg(REG_COEFF1, '0);
          write_reg(REG_COEFF2, {16'h4000, 16'h2000, 32'h0});
          write_reg(REG_MIN_SWING, {$urandom, 16'($urandom), 16'($urandom_range(50))});
          write_reg(REG_MAX_SWING,
                    {$urandom, 16'($urandom), 16'($urandom_range(2000, 100))});
        end
      endcase

      phase_end = sent_items + PHASE_ITEMS;
      while (sent_items < phase_end) begin
        if ($urandom_range(9) < 8) begin
          // triangle pulse train on a random baseline
          len    = $urandom_range(80, 20);
          period = $urandom_range(64, 6);
          half   = period / 2;
          amp    = ($urandom_range(9) == 0) ? $urandom_range(30000, 600)
                                            : $urandom_range(600, 5);
          base   = $urandom_range(65535 - amp, amp);
          hi     = ($urandom_range(7) == 0) ? $urandom_range(3) : 0;
          for (int t = 0; t < len; t++) begin
            ph = t % period;
            if (ph < half) v = 2 * amp * ph / half - amp;
            else v = amp - 2 * amp * (ph - half) / (period - half);
            n = $urandom_range(6);
            s = base + v + n - 3;
            if (s < 0) s = 0;
            else if (s > 65535) s = 65535;
            push_sample({hi[1:0], s[15:0]}, 1'b0, '0);
          end
        end else begin
          len = $urandom_range(15, 3);
          for (int k = 0; k < len; k++) begin
            case ($urandom_range(3))
              0: noise_s = '0;
              1: noise_s = '1;
              default: noise_s = $urandom;
            endcase
            push_sample(noise_s, 1'b0, '0);
          end
        end
      end
      phase_no++;
    end

    in_bus.valid <= 1'b0;
    while (pending_pulses.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
